// ===== sv/chs_geometry_from_sectors_defines.svh =====
// Assertion macros for the CHS geometry block and its checker.
// Depends on clk_i and rst_ni being visible where the macros are used.
`ifndef CHS_GEOMETRY_FROM_SECTORS_DEFINES_SVH
`define CHS_GEOMETRY_FROM_SECTORS_DEFINES_SVH

// Implication sampled on the rising clock edge, off while in reset.
`define CHS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must never hold outside reset.
`define CHS_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

`endif

// ===== sv/chs_geo_pkg.sv =====
// Constants and reciprocal tables for the CHS geometry pipeline.
// No dependencies.
package chs_geo_pkg;

  localparam int unsigned SecW   = 28;
  localparam int unsigned QuoW   = 24;
  localparam int unsigned CthW   = 20;
  localparam int unsigned RecW   = 29;
  localparam int unsigned HdRecW = 23;
  localparam int unsigned HdSh   = 24;

  localparam logic [31:0] SECTORS_MAX   = 32'(65535 * 16 * 255);
  localparam logic [31:0] SECTORS_LARGE = 32'(65535 * 16 * 63);

  localparam int unsigned Sh17  = 33;
  localparam int unsigned Sh31  = 33;
  localparam int unsigned Sh63  = 34;
  localparam int unsigned Sh255 = 36;

  localparam logic [RecW-1:0] RECIP17  = RecW'(((64'd1 << Sh17) + 64'd16) / 64'd17);
  localparam logic [RecW-1:0] RECIP31  = RecW'(((64'd1 << Sh31) + 64'd30) / 64'd31);
  localparam logic [RecW-1:0] RECIP63  = RecW'(((64'd1 << Sh63) + 64'd62) / 64'd63);
  localparam logic [RecW-1:0] RECIP255 = RecW'(((64'd1 << Sh255) + 64'd254) / 64'd255);

  localparam logic [7:0] SPT17  = 8'd17;
  localparam logic [7:0] SPT31  = 8'd31;
  localparam logic [7:0] SPT63  = 8'd63;
  localparam logic [7:0] SPT255 = 8'd255;

  localparam logic [4:0] HEADS_MIN = 5'd4;
  localparam logic [4:0] HEADS_MAX = 5'd16;

  // ceil(2^24 / h) for h in 4..16
  function automatic logic [HdRecW-1:0] head_recip(input logic [4:0] h);
    logic [HdRecW-1:0] r;
    case (h)
      5'd4:    r = 23'd4194304;
      5'd5:    r = 23'd3355444;
      5'd6:    r = 23'd2796203;
      5'd7:    r = 23'd2396746;
      5'd8:    r = 23'd2097152;
      5'd9:    r = 23'd1864136;
      5'd10:   r = 23'd1677722;
      5'd11:   r = 23'd1525202;
      5'd12:   r = 23'd1398102;
      5'd13:   r = 23'd1290556;
      5'd14:   r = 23'd1198373;
      5'd15:   r = 23'd1118482;
      5'd16:   r = 23'd1048576;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/chs_geometry_from_sectors.sv =====
// CHS geometry from a sector count: four-stage pipeline, one request per cycle.
// The valid bit moves through s1_valid_q, s2_valid_q, s3_valid_q and done_q; done_o is done_q.
// Stages: clamp, constant-reciprocal divides, geometry select, head divide.
// busy stays low; the receiver cannot stall and no request is ever held off.
// Reset (rst_ni low, asynchronous) clears the valid bits only.
// Depends on chs_geo_pkg.
module chs_geometry_from_sectors (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] sector_count_i,
  output logic        done_o,
  output logic [15:0] cylinders_o,
  output logic [4:0]  heads_o,
  output logic [7:0]  sectors_per_track_o,
  output logic [31:0] geometry_word_o
);
  import chs_geo_pkg::*;

  // stage 1
  logic            s1_valid_q, s1_valid_d;
  logic [SecW-1:0] s1_secs_q, s1_secs_d;
  logic            s1_large_q, s1_large_d;
  // stage 2
  logic            s2_valid_q;
  logic            s2_large_q;
  logic [QuoW-1:0] s2_q17_q, s2_q17_d;
  logic [QuoW-1:0] s2_q31_q, s2_q31_d;
  logic [QuoW-1:0] s2_q63_q, s2_q63_d;
  logic [QuoW-1:0] s2_q255_q, s2_q255_d;
  // stage 3
  logic            s3_valid_q;
  logic [CthW-1:0] s3_cth_q, s3_cth_d;
  logic [4:0]      s3_heads_q, s3_heads_d;
  logic [7:0]      s3_spt_q, s3_spt_d;
  // stage 4
  logic            done_q;
  logic [15:0]     cyl_q, cyl_d;
  logic [4:0]      heads_q;
  logic [7:0]      spt_q;

  logic [SecW+RecW-1:0]   p17, p31, p63, p255;
  logic [CthW+HdRecW-1:0] p_hd;
  logic [14:0]            hd_ceil, heads17;
  logic                   sw1;

  assign busy       = 1'b0;
  assign s1_valid_d = start & ~busy;

  // clamp and classify
  always_comb begin
    s1_secs_d  = (sector_count_i > SECTORS_MAX) ? SECTORS_MAX[SecW-1:0]
                                                : sector_count_i[SecW-1:0];
    s1_large_d = ({4'b0, s1_secs_d} >= SECTORS_LARGE);
  end

  // divide by each candidate sectors-per-track
  always_comb begin
    p17  = (SecW+RecW)'(s1_secs_q) * (SecW+RecW)'(RECIP17);
    p31  = (SecW+RecW)'(s1_secs_q) * (SecW+RecW)'(RECIP31);
    p63  = (SecW+RecW)'(s1_secs_q) * (SecW+RecW)'(RECIP63);
    p255 = (SecW+RecW)'(s1_secs_q) * (SecW+RecW)'(RECIP255);
    s2_q17_d  = p17[Sh17+QuoW-1:Sh17];
    s2_q31_d  = p31[Sh31+QuoW-1:Sh31];
    s2_q63_d  = QuoW'(p63[SecW+RecW-1:Sh63]);
    s2_q255_d = QuoW'(p255[SecW+RecW-1:Sh255]);
  end

  // pick the geometry
  always_comb begin
    hd_ceil = {1'b0, s2_q17_q[QuoW-1:10]} + 15'(s2_q17_q[9:0] != 10'd0);
    heads17 = (hd_ceil < 15'(HEADS_MIN)) ? 15'(HEADS_MIN) : hd_ceil;
    sw1     = ({1'b0, s2_q17_q} >= {heads17, 10'b0}) || (heads17 > 15'(HEADS_MAX));
    if (s2_large_q) begin
      s3_spt_d   = SPT255;
      s3_heads_d = HEADS_MAX;
      s3_cth_d   = s2_q255_q[CthW-1:0];
    end else if (!sw1) begin
      s3_spt_d   = SPT17;
      s3_heads_d = heads17[4:0];
      s3_cth_d   = s2_q17_q[CthW-1:0];
    end else if (s2_q31_q >= QuoW'(16384)) begin
      s3_spt_d   = SPT63;
      s3_heads_d = HEADS_MAX;
      s3_cth_d   = s2_q63_q[CthW-1:0];
    end else begin
      s3_spt_d   = SPT31;
      s3_heads_d = HEADS_MAX;
      s3_cth_d   = s2_q31_q[CthW-1:0];
    end
  end

  // cylinders = tracks / heads
  always_comb begin
    p_hd  = (CthW+HdRecW)'(s3_cth_q) * (CthW+HdRecW)'(head_recip(s3_heads_q));
    cyl_d = p_hd[HdSh+15:HdSh];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      done_q     <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_secs_q  <= s1_secs_d;
    s1_large_q <= s1_large_d;
    s2_large_q <= s1_large_q;
    s2_q17_q   <= s2_q17_d;
    s2_q31_q   <= s2_q31_d;
    s2_q63_q   <= s2_q63_d;
    s2_q255_q  <= s2_q255_d;
    s3_cth_q   <= s3_cth_d;
    s3_heads_q <= s3_heads_d;
    s3_spt_q   <= s3_spt_d;
    cyl_q      <= cyl_d;
    heads_q    <= s3_heads_q;
    spt_q      <= s3_spt_q;
  end

  assign done_o              = done_q;
  assign cylinders_o         = cyl_q;
  assign heads_o             = heads_q;
  assign sectors_per_track_o = spt_q;
  assign geometry_word_o     = {cyl_q, 3'b000, heads_q, spt_q};

endmodule

// ===== sv/chs_geo_checker.sv =====
// Port-level checker for the CHS geometry block, bound into chs_geometry_from_sectors.
// Depends on chs_geo_pkg and chs_geometry_from_sectors_defines.svh.
`include "chs_geometry_from_sectors_defines.svh"
module chs_geo_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [31:0] sector_count_i,
  input logic        done_o,
  input logic [15:0] cylinders_o,
  input logic [4:0]  heads_o,
  input logic [7:0]  sectors_per_track_o,
  input logic [31:0] geometry_word_o
);
  import chs_geo_pkg::*;

  `CHS_ASSERT_NEVER(a_never_busy, busy, "busy raised on a non-stalling pipeline")
  `CHS_ASSERT_IMP(a_latency, start && !busy, ##4 done_o, "request not answered after 4 cycles")
  `CHS_ASSERT_IMP(a_fields, done_o, (heads_o >= HEADS_MIN) && (heads_o <= HEADS_MAX) && ((sectors_per_track_o == SPT17) || (sectors_per_track_o == SPT31) || (sectors_per_track_o == SPT63) || (sectors_per_track_o == SPT255)), "geometry field out of range")
  `CHS_ASSERT_IMP(a_word, done_o, geometry_word_o == {cylinders_o, 3'b000, heads_o, sectors_per_track_o}, "packed word disagrees with fields")
  `CHS_ASSERT_IMP(a_large_heads, done_o && (sectors_per_track_o != SPT17), heads_o == HEADS_MAX, "head count not sixteen above 17 sectors per track")

endmodule

bind chs_geometry_from_sectors chs_geo_checker u_chs_geo_checker (.*);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for chs_geometry_from_sectors: a directed table of sector counts, then bursty
// random requests; every result is checked field by field against its typed table entry or a local geometry predictor.
// Depends on chs_geo_pkg and the chs_geometry_from_sectors RTL.
module tb_top;
  import chs_geo_pkg::*;

  localparam int unsigned RandomRequests = 1880;
  localparam int unsigned IdleLimit      = 400;
  localparam int unsigned DrainCycles    = 16;
  localparam int unsigned ReportLimit    = 10;
  localparam int unsigned DirectedRows   = 24;

  typedef struct packed {
    logic [15:0] cylinders;
    logic [4:0]  heads;
    logic [7:0]  spt;
    logic [31:0] word;
  } geometry_t;

  typedef struct packed {
    logic [31:0] secs;
    logic        typed;
    geometry_t   geo;
  } stim_row_t;

  localparam geometry_t GeoZero = '{16'd0, 5'd4, 8'd17, 32'h0000_0411};
  localparam geometry_t GeoFull = '{16'hFFFF, 5'd16, 8'd255, 32'hFFFF_10FF};

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        start          = 1'b0;
  logic [31:0] sector_count_i = '0;
  logic        busy;
  logic        done_o;
  logic [15:0] cylinders_o;
  logic [4:0]  heads_o;
  logic [7:0]  sectors_per_track_o;
  logic [31:0] geometry_word_o;

  geometry_t   geometry_to_send[$];
  geometry_t   geometry_in_flight[$];
  int unsigned mismatches    = 0;
  int unsigned requests_seen = 0;
  int unsigned results_seen  = 0;
  int unsigned idle_cycles   = 0;
  int unsigned spt_hits[4]   = '{0, 0, 0, 0};

  stim_row_t directed_rows [DirectedRows] = '{
    '{32'd0,                   1'b1, GeoZero},
    '{32'd1,                   1'b0, '0},
    '{32'd16,                  1'b0, '0},
    '{32'd17,                  1'b0, '0},
    '{32'd69631,               1'b0, '0},
    '{32'd69632,               1'b0, '0},
    '{32'd87040,               1'b0, '0},
    '{32'd278527,              1'b0, '0},
    '{32'd278528,              1'b0, '0},
    '{32'd295953,              1'b0, '0},
    '{32'd507903,              1'b0, '0},
    '{32'd507904,              1'b0, '0},
    '{32'h0000_FFFF,           1'b0, '0},
    '{32'h00FF_00FF,           1'b0, '0},
    '{SECTORS_LARGE - 32'd1,   1'b0, '0},
    '{SECTORS_LARGE,           1'b0, '0},
    '{SECTORS_MAX - 32'd1,     1'b0, '0},
    '{SECTORS_MAX,             1'b1, GeoFull},
    '{SECTORS_MAX + 32'd1,     1'b1, GeoFull},
    '{32'h5555_5555,           1'b1, GeoFull},
    '{32'h7FFF_FFFF,           1'b1, GeoFull},
    '{32'h8000_0000,           1'b1, GeoFull},
    '{32'hAAAA_AAAA,           1'b1, GeoFull},
    '{32'hFFFF_FFFF,           1'b1, GeoFull}
  };

  chs_geometry_from_sectors dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .sector_count_i      (sector_count_i),
    .done_o              (done_o),
    .cylinders_o         (cylinders_o),
    .heads_o             (heads_o),
    .sectors_per_track_o (sectors_per_track_o),
    .geometry_word_o     (geometry_word_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic geometry_t predict_geometry(input logic [31:0] secs_in);
    logic [31:0] secs;
    logic [31:0] spt;
    logic [31:0] hds;
    logic [31:0] tracks;
    logic [31:0] cyl;
    geometry_t   g;
    secs = (secs_in > SECTORS_MAX) ? SECTORS_MAX : secs_in;
    if (secs >= SECTORS_LARGE) begin
      spt = 32'(SPT255);
      hds = 32'(HEADS_MAX);
    end else begin
      spt    = 32'(SPT17);
      tracks = secs / spt;
      hds    = (tracks + 32'd1023) / 32'd1024;
      if (hds < 32'(HEADS_MIN)) hds = 32'(HEADS_MIN);
      if (tracks >= hds * 32'd1024 || hds > 32'(HEADS_MAX)) begin
        spt    = 32'(SPT31);
        hds    = 32'(HEADS_MAX);
        tracks = secs / spt;
      end
      if (tracks >= hds * 32'd1024) spt = 32'(SPT63);
    end
    tracks      = secs / spt;
    cyl         = tracks / hds;
    g.cylinders = cyl[15:0];
    g.heads     = hds[4:0];
    g.spt       = spt[7:0];
    g.word      = {cyl[15:0], 3'b000, hds[4:0], spt[7:0]};
    return g;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= ReportLimit)
      $display("%0t: %s: expected 0x%08h, got 0x%08h", $realtime, what, want, got);
  endtask

  task automatic issue_request(input logic [31:0] secs, input logic typed,
                               input geometry_t geo);
    geometry_to_send.push_back(typed ? geo : predict_geometry(secs));
    start          <= 1'b1;
    sector_count_i <= secs;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic idle_gap(input int unsigned cycles);
    start          <= 1'b0;
    sector_count_i <= $urandom();
    repeat (cycles) @(posedge clk_i);
  endtask

  // Accept requests, check results, watch for a hang
  always @(posedge clk_i) begin
    geometry_t want;
    logic      moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (start && !busy) begin
        moved = 1'b1;
        requests_seen++;
        if (geometry_to_send.size() != 0)
          geometry_in_flight.push_back(geometry_to_send.pop_front());
      end
      if (done_o) begin
        moved = 1'b1;
        results_seen++;
        case (sectors_per_track_o)
          SPT17:   spt_hits[0]++;
          SPT31:   spt_hits[1]++;
          SPT63:   spt_hits[2]++;
          SPT255:  spt_hits[3]++;
          default: ;
        endcase
        if (geometry_in_flight.size() == 0) begin
          note_mismatch("result with no request outstanding", '0, geometry_word_o);
        end else begin
          want = geometry_in_flight.pop_front();
          if (cylinders_o !== want.cylinders)
            note_mismatch("cylinders", 32'(want.cylinders), 32'(cylinders_o));
          if (heads_o !== want.heads)
            note_mismatch("heads", 32'(want.heads), 32'(heads_o));
          if (sectors_per_track_o !== want.spt)
            note_mismatch("sectors per track", 32'(want.spt), 32'(sectors_per_track_o));
          if (geometry_word_o !== want.word)
            note_mismatch("geometry word", want.word, geometry_word_o);
        end
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Watchdog: no progress for %0d cycles", IdleLimit);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int unsigned burst_left;
    int unsigned k;
    logic [31:0] secs;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      issue_request(directed_rows[i].secs, directed_rows[i].typed, directed_rows[i].geo);
      if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 3));
    end

    burst_left = 0;
    for (int unsigned n = 0; n < RandomRequests; n++) begin
      if (burst_left == 0) begin
        if (n < 600 || n > 900) idle_gap($urandom_range(1, 6));
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                 : $urandom_range(1, 30);
      end
      burst_left--;
      case ($urandom_range(0, 9))
        0, 1, 2: secs = $urandom_range(0, 600000);
        3, 4:    secs = $urandom_range(600000, SECTORS_LARGE - 32'd1);
        5, 6: begin
          // straddle the 17 and 31 sectors-per-track head boundaries
          k    = $urandom_range(1, 24);
          secs = k * (($urandom_range(0, 1) == 1) ? 32'd17408 : 32'd31744)
                 + $urandom_range(0, 64) - 32'd32;
        end
        7:       secs = $urandom_range(SECTORS_LARGE, SECTORS_MAX);
        default: secs = $urandom();
      endcase
      issue_request(secs, 1'b0, '0);
    end
    start <= 1'b0;

    while (geometry_to_send.size() != 0 || geometry_in_flight.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (geometry_in_flight.size() != 0) begin
      mismatches += geometry_in_flight.size();
      $display("%0d results never arrived", geometry_in_flight.size());
    end
    $display("Covered %0d requests and %0d results, directed table then bursty random.",
             requests_seen, results_seen);
    $display("Geometry mix by sectors per track 17/31/63/255: %0d/%0d/%0d/%0d",
             spt_hits[0], spt_hits[1], spt_hits[2], spt_hits[3]);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
